// ===== rtl/prbc_pkg.sv =====
// Shared types and constants for the packet ring buffer with commit.
// Used by prbc_front, prbc_back, prbc_outq and the top level.
`default_nettype none

package prbc_pkg;

    // Request codes as they arrive on req_type
    localparam logic [1:0] REQ_WR_HDR  = 2'd0;
    localparam logic [1:0] REQ_WR_DATA = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_ACK     = 2'd3;

    // Queue sizes between the parts
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;
    localparam int CQ_CW    = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef enum logic [1:0] {
        OP_HDR,
        OP_DATA,
        OP_READ,
        OP_ACK
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVF,
        ST_EMPTY
    } status_t;

    // One classified command from the front to the back
    typedef struct packed {
        op_t        op;
        logic [6:0] length;
        logic [7:0] data_byte;
    } cmd_t;

    // One result word
    typedef struct packed {
        status_t    status;
        logic [7:0] data_byte;
        logic [5:0] pending_count;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/prbc_front.sv =====
// Front part: accepts request words, classifies them and queues commands.
// Depends on prbc_pkg for the command type and request codes.
`default_nettype none

module prbc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         req_type,
    input  wire logic [6:0]         length,
    input  wire logic [7:0]         data_byte,
    output logic                    cmd_valid,
    output prbc_pkg::cmd_t          cmd,
    input  wire logic               cmd_take
);

    prbc_pkg::cmd_t                  cq_mem [prbc_pkg::CQ_DEPTH];
    logic [prbc_pkg::CQ_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [prbc_pkg::CQ_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [prbc_pkg::CQ_CW-1:0]      count_reg, count_next;
    prbc_pkg::cmd_t                  in_cmd;
    logic                            do_push;

    // Classify the request code
    always_comb
    begin
        in_cmd.length    = length;
        in_cmd.data_byte = data_byte;
        unique case (req_type)
            prbc_pkg::REQ_WR_HDR:  in_cmd.op = prbc_pkg::OP_HDR;
            prbc_pkg::REQ_WR_DATA: in_cmd.op = prbc_pkg::OP_DATA;
            prbc_pkg::REQ_READ:    in_cmd.op = prbc_pkg::OP_READ;
            prbc_pkg::REQ_ACK:     in_cmd.op = prbc_pkg::OP_ACK;
            default:               in_cmd.op = prbc_pkg::OP_ACK;
        endcase
    end

    assign full      = (count_reg == prbc_pkg::CQ_CW'(prbc_pkg::CQ_DEPTH));
    assign do_push   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cq_mem[rd_ptr_reg];

    // Advance queue pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !cmd_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cq_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prbc_back.sv =====
// Back part: ring pointers, byte store, read streaming and result staging.
// Depends on prbc_pkg for command and result types.
`default_nettype none

module prbc_back #(
    parameter int DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire prbc_pkg::cmd_t              cmd,
    output logic                             cmd_take,
    input  wire logic [prbc_pkg::OQ_CW-1:0]  oq_count,
    output logic                             res_valid,
    output prbc_pkg::res_t                   res
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    typedef enum logic {
        S_CMD,
        S_STREAM
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [PW-1:0]   mark_reg, mark_next;
    logic [6:0]      rem_reg, rem_next;
    logic [PW-1:0]   cursor_reg, cursor_next;
    logic [PW-1:0]   sptr_reg, sptr_next;
    logic [PW-1:0]   left_reg, left_next;
    logic [PW-1:0]   total_reg, total_next;

    logic [7:0]      store_mem [DEPTH];
    logic [7:0]      mem_q_reg;

    logic            s2_valid_reg;
    prbc_pkg::res_t  s2_res_reg;
    logic            s2_mem_reg;

    logic            can_issue;
    logic            emit;
    prbc_pkg::res_t  emit_res;
    logic            emit_mem;
    logic            mem_we;
    logic [PW:0]     used_wide;
    logic [PW-1:0]   used;
    logic [PW-1:0]   free_space;
    logic [PW-1:0]   cursor_inc;
    logic [PW-1:0]   sptr_inc;

    // Count committed bytes and free space
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            used_wide = (PW+1)'(wp_reg) - (PW+1)'(rp_reg);
        end
        else
        begin
            used_wide = (PW+1)'(wp_reg) + (PW+1)'(DEPTH) - (PW+1)'(rp_reg);
        end
        used       = used_wide[PW-1:0];
        free_space = LAST_IDX - used;
        cursor_inc = (cursor_reg == LAST_IDX) ? '0 : cursor_reg + 1'b1;
        sptr_inc   = (sptr_reg == LAST_IDX) ? '0 : sptr_reg + 1'b1;
    end

    // Issue only with a guaranteed slot in the result queue
    assign can_issue = ((oq_count + prbc_pkg::OQ_CW'(s2_valid_reg))
                        < prbc_pkg::OQ_CW'(prbc_pkg::OQ_DEPTH));
    assign cmd_take  = cmd_valid && (state_reg == S_CMD) && can_issue;

    // Carry out one command or one streamed byte
    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        mark_next   = mark_reg;
        rem_next    = rem_reg;
        cursor_next = cursor_reg;
        sptr_next   = sptr_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        emit        = 1'b0;
        emit_mem    = 1'b0;
        mem_we      = 1'b0;
        emit_res.status        = prbc_pkg::ST_OK;
        emit_res.data_byte     = '0;
        emit_res.pending_count = '0;
        emit_res.last          = 1'b1;

        unique case (state_reg)
            S_STREAM:
            begin
                if (can_issue)
                begin
                    emit     = 1'b1;
                    emit_mem = 1'b1;
                    emit_res.pending_count = 6'(total_reg);
                    emit_res.last          = (left_reg == PW'(1));
                    sptr_next = sptr_inc;
                    left_next = left_reg - 1'b1;
                    if (left_reg == PW'(1))
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                if (cmd_take)
                begin
                    unique case (cmd.op)
                        prbc_pkg::OP_HDR:
                        begin
                            emit = 1'b1;
                            if ((free_space == '0) || (cmd.length > 7'(free_space)))
                            begin
                                emit_res.status = prbc_pkg::ST_OVF;
                                rem_next        = '0;
                            end
                            else
                            begin
                                rem_next    = cmd.length;
                                cursor_next = wp_reg;
                            end
                        end
                        prbc_pkg::OP_DATA:
                        begin
                            emit = 1'b1;
                            if (rem_reg == '0)
                            begin
                                emit_res.status = prbc_pkg::ST_OVF;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                cursor_next = cursor_inc;
                                rem_next    = rem_reg - 1'b1;
                                if (rem_reg == 7'd1)
                                begin
                                    wp_next = cursor_inc;
                                end
                            end
                        end
                        prbc_pkg::OP_READ:
                        begin
                            if (used == '0)
                            begin
                                emit            = 1'b1;
                                emit_res.status = prbc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_STREAM;
                                sptr_next  = rp_reg;
                                left_next  = used;
                                total_next = used;
                                mark_next  = wp_reg;
                            end
                        end
                        prbc_pkg::OP_ACK:
                        begin
                            emit    = 1'b1;
                            rp_next = mark_reg;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CMD;
            end
        endcase
    end

    // Hold state, pointers and the staged result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CMD;
            wp_reg       <= '0;
            rp_reg       <= '0;
            mark_reg     <= '0;
            rem_reg      <= '0;
            cursor_reg   <= '0;
            sptr_reg     <= '0;
            left_reg     <= '0;
            total_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            mark_reg     <= mark_next;
            rem_reg      <= rem_next;
            cursor_reg   <= cursor_next;
            sptr_reg     <= sptr_next;
            left_reg     <= left_next;
            total_reg    <= total_next;
            s2_valid_reg <= emit;
        end
    end

    // Stage result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s2_res_reg <= emit_res;
            s2_mem_reg <= emit_mem;
        end
    end

    // Write bytes into the store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[cursor_reg] <= cmd.data_byte;
        end
    end

    // Read the streamed byte, registered
    always_ff @(posedge clk)
    begin
        if (emit_mem)
        begin
            mem_q_reg <= store_mem[sptr_reg];
        end
    end

    always_comb
    begin
        res           = s2_res_reg;
        res.data_byte = s2_mem_reg ? mem_q_reg : 8'd0;
    end

    assign res_valid = s2_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/prbc_outq.sv =====
// Result queue: holds finished result words until the receiver pops them.
// Depends on prbc_pkg for the result type and queue size.
`default_nettype none

module prbc_outq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire prbc_pkg::res_t              in_res,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [prbc_pkg::OQ_CW-1:0]       count,
    output prbc_pkg::res_t                   out_res
);

    prbc_pkg::res_t                  oq_mem [prbc_pkg::OQ_DEPTH];
    logic [prbc_pkg::OQ_AW-1:0]      wr_ptr_reg;
    logic [prbc_pkg::OQ_AW-1:0]      rd_ptr_reg;
    logic [prbc_pkg::OQ_CW-1:0]      count_reg, count_next;
    logic                            do_pop;

    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_pop  = pop && !empty;
    assign out_res = oq_mem[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!in_valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Hold result words
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            oq_mem[wr_ptr_reg] <= in_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/packet_ring_buffer_with_commit_core.sv =====
// Packet ring buffer with commit: top level.
// Instantiates prbc_front, prbc_back and prbc_outq; uses prbc_pkg.
//
// Usage:
//   Requests enter through a queue-like port: drive req_type, length and
//   data_byte with push high; the word is taken at a clock edge where full
//   is low. Results leave through a queue-like port: while empty is low the
//   oldest result sits on status, data_byte_res, pending_count and last, and
//   pop high takes it.
//   Header, data and acknowledge requests give one result word each and
//   flow at one request per cycle while no read streams and the result queue
//   has room. A read of N committed bytes gives N words (or one empty-status
//   word when nothing is pending) and holds the back end until its last byte,
//   one store read per byte. A result word passes the staging register, then
//   the result queue; a non-empty read first moves the back end to streaming.
//   A 2-word command queue parts the input from the back end, and a 4-word
//   result queue parts the back end from the receiver. When the receiver
//   stalls, the back end stops issuing once the result queue is committed,
//   the command queue fills and full rises.
//   Reset clears the pointers, the commit mark, the open write and both
//   queues. The byte store is not cleared; only written bytes are ever read.
`default_nettype none

module packet_ring_buffer_with_commit_core #(
    parameter int DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  req_type,
    input  wire logic [6:0]  length,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [7:0]       data_byte_res,
    output logic [5:0]       pending_count,
    output logic             last
);

    logic                            cmd_valid;
    prbc_pkg::cmd_t                  cmd;
    logic                            cmd_take;
    logic [prbc_pkg::OQ_CW-1:0]      oq_count;
    logic                            res_valid;
    prbc_pkg::res_t                  res;
    prbc_pkg::res_t                  out_res;

    prbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .length    (length),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    prbc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .oq_count  (oq_count),
        .res_valid (res_valid),
        .res       (res)
    );

    prbc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (res),
        .pop      (pop),
        .empty    (empty),
        .count    (oq_count),
        .out_res  (out_res)
    );

    // Split the result word onto the ports
    assign status        = out_res.status;
    assign data_byte_res = out_res.data_byte;
    assign pending_count = out_res.pending_count;
    assign last          = out_res.last;

    // The result queue never takes a word while it is full
    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && (oq_count == prbc_pkg::OQ_CW'(prbc_pkg::OQ_DEPTH))))
        else $error("result queue overflow");

    // The back end takes a command only when one is queued
    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty queue");

    // A word that is not last belongs to a read run with a byte count
    a_run_word: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |->
        ((res.status == prbc_pkg::ST_OK) && (res.pending_count != 6'd0)))
        else $error("non-final word outside a read run");

    // While a word that is not last is staged, the run is still streaming
    a_run_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |-> !cmd_take)
        else $error("command taken in the middle of a read run");

endmodule

`default_nettype wire
